### rtl/msttsp_pkg.sv
// Package for the MST tour block: sizes, the queued item type.
// Used by every module of the block but msttsp_ram; depends on nothing.
`default_nettype none
package msttsp_pkg;
	localparam int MAX_NODES   = 64;
	localparam int NODE_W      = 6;
	localparam int CNT_W       = 7;
	localparam int WEIGHT_BITS = 32;
	localparam int COST_W      = 38;
	localparam int WADDR_W     = 2 * NODE_W;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;

	typedef struct packed {
		logic [NODE_W-1:0]      row;
		logic [NODE_W-1:0]      col;
		logic [WEIGHT_BITS-1:0] weight;
		logic                   last;
	} item_t;
endpackage
`default_nettype wire

### rtl/msttsp_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module msttsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/msttsp_front.sv
// Input stage: take a matrix beat, register it, hand it to the queue.
// Depends on msttsp_pkg.
`default_nettype none
module msttsp_front import msttsp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [NODE_W-1:0]      row,
	input  wire logic [NODE_W-1:0]      col,
	input  wire logic [WEIGHT_BITS-1:0] weight,
	input  wire logic                   last,
	output logic                        push_valid,
	output item_t                       push_item,
	input  wire logic                   push_ready
);
	logic  vld_s1;
	item_t item_s1;
	logic  accept;

	assign in_stall   = vld_s1 && !push_ready;
	assign accept     = in_valid && !in_stall;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.row    <= row;
			item_s1.col    <= col;
			item_s1.weight <= weight;
			item_s1.last   <= last;
		end
	end
endmodule
`default_nettype wire

### rtl/msttsp_queue.sv
// Short FIFO of matrix items between the input stage and the solver.
// Depends on msttsp_pkg.
`default_nettype none
module msttsp_queue import msttsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	input  item_t     push_item,
	output logic      push_ready,
	output logic      pop_valid,
	output item_t     pop_item,
	input  wire logic pop
);
	item_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign push_ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = ent_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

### rtl/msttsp_back.sv
// Solver: stores weights, runs dense Prim, preorder walk, cost, emits tour.
// Depends on msttsp_pkg and msttsp_ram.
`default_nettype none
module msttsp_back import msttsp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_node_count,
	input  wire logic              pop_valid,
	input  item_t                  pop_item,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [NODE_W-1:0]      vertex,
	output logic [COST_W-1:0]      tour_cost,
	output logic                   last_res
);
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_RELAX   = 4'd1;
	localparam logic [3:0] ST_RDRAIN  = 4'd2;
	localparam logic [3:0] ST_RDEC    = 4'd3;
	localparam logic [3:0] ST_WINIT   = 4'd4;
	localparam logic [3:0] ST_WPOP    = 4'd5;
	localparam logic [3:0] ST_WPOPD   = 4'd6;
	localparam logic [3:0] ST_WSCAN   = 4'd7;
	localparam logic [3:0] ST_WSDRAIN = 4'd8;
	localparam logic [3:0] ST_CLOSE   = 4'd9;
	localparam logic [3:0] ST_CLOSED  = 4'd10;
	localparam logic [3:0] ST_ORD     = 4'd11;
	localparam logic [3:0] ST_ORDD    = 4'd12;
	localparam logic [3:0] ST_OUT     = 4'd13;

	logic [3:0]             state_q;
	logic [CNT_W-1:0]       nc_q, n_q, cnt_q, sp_q, tlen_q, idx_q;
	logic [NODE_W-1:0]      u_q, prev_q, v_s1, best_idx_q;
	logic [MAX_NODES-1:0]   in_tree_q, keyv_q;
	logic                   best_found_q, rs1_vld, ps1_vld, add_pend_q;
	logic [WEIGHT_BITS-1:0] best_key_q;
	logic [COST_W-1:0]      cost_q;

	logic                   w_we;
	logic [WADDR_W-1:0]     w_waddr, w_raddr;
	logic [WEIGHT_BITS-1:0] w_rdata, k_rdata;
	logic [NODE_W-1:0]      p_rdata, s_rdata, t_rdata, p_raddr, s_raddr, s_waddr, s_wdata;
	logic                   s_we, k_we;
	logic [CNT_W-1:0]       n_eff;

	logic                   upd, nkv, better, match;
	logic [WEIGHT_BITS-1:0] nk;

	// clamp node count into 1..MAX_NODES
	always_comb begin
		priority if (nc_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (nc_q > CNT_W'(MAX_NODES)) begin
			n_eff = CNT_W'(MAX_NODES);
		end else begin
			n_eff = nc_q;
		end
	end

	assign pop     = pop_valid && (state_q == ST_IDLE);
	assign w_we    = pop;
	assign w_waddr = {pop_item.row, pop_item.col};

	always_comb begin
		unique case (state_q)
			ST_WPOPD: w_raddr = {prev_q, s_rdata};
			ST_CLOSE: w_raddr = {prev_q, NODE_W'(0)};
			default:  w_raddr = {u_q, cnt_q[NODE_W-1:0]};
		endcase
	end

	// relax compare on returned weight and key
	always_comb begin
		upd    = !in_tree_q[v_s1] && (w_rdata != '0) && (!keyv_q[v_s1] || w_rdata < k_rdata);
		nk     = upd ? w_rdata : k_rdata;
		nkv    = keyv_q[v_s1] || upd;
		better = !in_tree_q[v_s1] && nkv && (!best_found_q || nk < best_key_q);
		match  = keyv_q[v_s1] && (v_s1 != '0) && (p_rdata == prev_q);
	end

	assign k_we    = rs1_vld && upd;
	assign p_raddr = NODE_W'(cnt_q - 1'b1);
	assign s_raddr = NODE_W'(sp_q - 1'b1);
	assign s_we    = (state_q == ST_WINIT) || (ps1_vld && match);
	assign s_waddr = (state_q == ST_WINIT) ? '0 : sp_q[NODE_W-1:0];
	assign s_wdata = (state_q == ST_WINIT) ? '0 : v_s1;

	msttsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_wram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(pop_item.weight),
		.raddr(w_raddr), .rdata(w_rdata)
	);
	msttsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES)) u_kram (
		.clk(clk), .we(k_we), .waddr(v_s1), .wdata(w_rdata),
		.raddr(cnt_q[NODE_W-1:0]), .rdata(k_rdata)
	);
	msttsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pram (
		.clk(clk), .we(k_we), .waddr(v_s1), .wdata(u_q),
		.raddr(p_raddr), .rdata(p_rdata)
	);
	msttsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_sram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	msttsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_tram (
		.clk(clk), .we(state_q == ST_WPOPD), .waddr(tlen_q[NODE_W-1:0]),
		.wdata(s_rdata), .raddr(idx_q[NODE_W-1:0]), .rdata(t_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nc_q         <= CNT_W'(MAX_NODES);
			n_q          <= '0;
			cnt_q        <= '0;
			sp_q         <= '0;
			tlen_q       <= '0;
			idx_q        <= '0;
			u_q          <= '0;
			prev_q       <= '0;
			v_s1         <= '0;
			best_idx_q   <= '0;
			best_key_q   <= '0;
			cost_q       <= '0;
			in_tree_q    <= '0;
			keyv_q       <= '0;
			best_found_q <= 1'b0;
			rs1_vld      <= 1'b0;
			ps1_vld      <= 1'b0;
			add_pend_q   <= 1'b0;
			out_valid    <= 1'b0;
			vertex       <= '0;
			tour_cost    <= '0;
			last_res     <= 1'b0;
		end else begin
			if (cfg_we) begin
				nc_q <= cfg_node_count;
			end
			rs1_vld <= 1'b0;
			ps1_vld <= 1'b0;
			if (add_pend_q) begin
				cost_q     <= cost_q + COST_W'(w_rdata);
				add_pend_q <= 1'b0;
			end
			if (rs1_vld) begin
				if (upd) begin
					keyv_q[v_s1] <= 1'b1;
				end
				if (better) begin
					best_found_q <= 1'b1;
					best_idx_q   <= v_s1;
					best_key_q   <= nk;
				end
			end
			if (ps1_vld && match) begin
				sp_q <= sp_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && pop_item.last) begin
						n_q          <= n_eff;
						u_q          <= '0;
						in_tree_q    <= MAX_NODES'(1);
						keyv_q       <= MAX_NODES'(1);
						cnt_q        <= '0;
						best_found_q <= 1'b0;
						state_q      <= ST_RELAX;
					end
				end
				ST_RELAX: begin
					rs1_vld <= 1'b1;
					v_s1    <= cnt_q[NODE_W-1:0];
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == n_q - 1'b1) begin
						state_q <= ST_RDRAIN;
					end
				end
				ST_RDRAIN: state_q <= ST_RDEC;
				ST_RDEC: begin
					if (best_found_q) begin
						u_q                   <= best_idx_q;
						in_tree_q[best_idx_q] <= 1'b1;
						cnt_q                 <= '0;
						best_found_q          <= 1'b0;
						state_q               <= ST_RELAX;
					end else begin
						state_q <= ST_WINIT;
					end
				end
				ST_WINIT: begin
					sp_q    <= CNT_W'(1);
					tlen_q  <= '0;
					cost_q  <= '0;
					state_q <= ST_WPOP;
				end
				ST_WPOP: begin
					if (sp_q == '0) begin
						state_q <= ST_CLOSE;
					end else begin
						sp_q    <= sp_q - 1'b1;
						state_q <= ST_WPOPD;
					end
				end
				ST_WPOPD: begin
					tlen_q     <= tlen_q + 1'b1;
					add_pend_q <= (tlen_q != '0);
					prev_q     <= s_rdata;
					cnt_q      <= n_q;
					state_q    <= ST_WSCAN;
				end
				ST_WSCAN: begin
					ps1_vld <= 1'b1;
					v_s1    <= p_raddr;
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_WSDRAIN;
					end
				end
				ST_WSDRAIN: state_q <= ST_WPOP;
				ST_CLOSE: begin
					add_pend_q <= 1'b1;
					state_q    <= ST_CLOSED;
				end
				ST_CLOSED: begin
					idx_q   <= '0;
					state_q <= ST_ORD;
				end
				ST_ORD: state_q <= ST_ORDD;
				ST_ORDD: begin
					out_valid <= 1'b1;
					vertex    <= t_rdata;
					last_res  <= (idx_q == tlen_q - 1'b1);
					tour_cost <= (idx_q == tlen_q - 1'b1) ? cost_q : '0;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						idx_q     <= idx_q + 1'b1;
						state_q   <= last_res ? ST_IDLE : ST_ORD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/mst_tsp_tour_approximation.sv
// Top level of the MST preorder tour block (2-approximation, dense Prim).
// Depends on msttsp_pkg, msttsp_front, msttsp_queue, msttsp_back.
//
// Use: stream matrix entries (row, col, weight) on the input channel, one
// beat per cycle while in_stall is low. A beat is taken when in_valid is
// high and in_stall low. The beat with last set is stored and starts a run.
// Entries pass through an input stage and a four-deep queue, so loading runs
// at one beat per cycle until a run occupies the solver; then the queue fills
// and in_stall rises until the run has delivered its last result.
// A run on n vertices takes up to n Prim steps and then a preorder walk,
// bounded by the single weight RAM read port and the parent scan; each tour
// vertex is then sent, held by any stall. Results come in visiting order;
// the final beat carries last_res and the cyclic cost, the others carry cost
// zero. out_stall high holds the current result beat unchanged. node_count
// is written on the cfg channel (always ready) while idle, a rule for the
// user that the block does not enforce; reset sets it to 64 and empties the
// queue. The weight store is not cleared.
`default_nettype none
module mst_tsp_tour_approximation import msttsp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CNT_W-1:0]       node_count,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [NODE_W-1:0]      row,
	input  wire logic [NODE_W-1:0]      col,
	input  wire logic [WEIGHT_BITS-1:0] weight,
	input  wire logic                   last,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [NODE_W-1:0]           vertex,
	output logic [COST_W-1:0]           tour_cost,
	output logic                        last_res
);
	logic  push_valid, push_ready, pop_valid, pop;
	item_t push_item, pop_item;

	// the register is a plain flop, take every write
	assign cfg_ready = 1'b1;

	msttsp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.row(row), .col(col), .weight(weight), .last(last),
		.push_valid(push_valid), .push_item(push_item), .push_ready(push_ready)
	);

	msttsp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_valid(push_valid), .push_item(push_item),
		.push_ready(push_ready), .pop_valid(pop_valid), .pop_item(pop_item), .pop(pop)
	);

	msttsp_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_valid && cfg_ready),
		.cfg_node_count(node_count), .pop_valid(pop_valid), .pop_item(pop_item),
		.pop(pop), .out_valid(out_valid), .out_stall(out_stall), .vertex(vertex),
		.tour_cost(tour_cost), .last_res(last_res)
	);
endmodule
`default_nettype wire
